// ----- hw/rtl/ir_pulse_code_decoder_unit_defines.svh -----
// assertion macros for the ir pulse code decoder
`ifndef IR_PULSE_CODE_DECODER_UNIT_DEFINES_SVH
`define IR_PULSE_CODE_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define IRPCD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define IRPCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IRPCD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define IRPCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/irpcd_pkg.sv -----
package irpcd_pkg;

  localparam int CODE_BITS  = 32;
  localparam int HEX_DIGITS = (CODE_BITS + 3) / 4;
  localparam int NIB_W      = HEX_DIGITS * 4;
  localparam int CNT_W      = $clog2(HEX_DIGITS + 1);
  localparam int THR_W      = 16;

  localparam int FQ_DEPTH = 2;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

  localparam logic [THR_W-1:0] THR_RESET = 16'h1000;
  localparam logic [7:0]       CHAR_NL   = 8'd10;
  localparam logic [7:0]       CHAR_ZERO = 8'd48;
  localparam logic [7:0]       CHAR_COLON = 8'd58;
  localparam logic [7:0]       ALPHA_GAP = 8'd7;

  typedef enum logic {
    OP_EDGE    = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_e;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
  } frame_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    c = {4'b0000, nib} + CHAR_ZERO;
    if (c >= CHAR_COLON) begin
      c = c + ALPHA_GAP;
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/irpcd_front.sv -----
module irpcd_front import irpcd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_data_i,
  input  logic             accept_i,
  input  logic             operation_i,
  input  logic [15:0]      interval_i,
  output logic             frame_push_o,
  output frame_t           frame_o
);

  logic [CODE_BITS-1:0] code_q, code_d;
  logic                 pending_q, pending_d;
  logic [THR_W-1:0]     thr_q;

  always_comb begin
    code_d       = code_q;
    pending_d    = pending_q;
    frame_push_o = 1'b0;
    if (accept_i) begin
      unique case (op_e'(operation_i))
        OP_EDGE: begin
          pending_d = 1'b1;
          if (interval_i == '0) begin
            frame_push_o = 1'b1;
            code_d       = '0;
          end else begin
            code_d = {code_q[CODE_BITS-2:0], (interval_i >= thr_q)};
          end
        end
        OP_TIMEOUT: begin
          if (pending_q) begin
            pending_d    = 1'b0;
            frame_push_o = 1'b1;
            code_d       = '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign frame_o.code = code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q    <= '0;
      pending_q <= 1'b0;
      thr_q     <= THR_RESET;
    end else begin
      code_q    <= code_d;
      pending_q <= pending_d;
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

endmodule

// ----- hw/rtl/irpcd_fifo.sv -----
module irpcd_fifo import irpcd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output frame_t data_o
);

  frame_t             mem_q [FQ_DEPTH];
  logic [FQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FQ_CW-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == FQ_CW'(FQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/irpcd_back.sv -----
module irpcd_back import irpcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fq_empty_i,
  input  frame_t     fq_data_i,
  output logic       fq_pop_o,
  output logic       busy_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] text_byte_o,
  output logic       last_of_frame_o
);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NIB_W-1:0] code_q, code_d;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             emit, is_nl;

  assign is_nl    = (cnt_q == CNT_W'(HEX_DIGITS));
  // output slot is free or drains this cycle
  assign emit     = busy_q && (!out_vld_q || pop_i);
  assign fq_pop_o = !busy_q && !fq_empty_i;

  always_comb begin
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    code_d    = code_q;
    out_vld_d = out_vld_q;
    byte_d    = byte_q;
    last_d    = last_q;
    if (out_vld_q && pop_i) begin
      out_vld_d = 1'b0;
    end
    if (fq_pop_o) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      code_d = NIB_W'(fq_data_i.code);
    end else if (emit) begin
      out_vld_d = 1'b1;
      last_d    = is_nl;
      byte_d    = is_nl ? CHAR_NL : hex_char(code_q[NIB_W-1 -: 4]);
      code_d    = code_q << 4;
      cnt_d     = cnt_q + 1'b1;
      if (is_nl) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign busy_o          = busy_q;
  assign empty_o         = !out_vld_q;
  assign text_byte_o     = byte_q;
  assign last_of_frame_o = last_q;

endmodule

// ----- hw/rtl/ir_pulse_code_decoder_unit.sv -----
// ir pulse-distance code decoder
// input queue side: push with operation_i / interval_i, taken when full is low.
//   an edge with a nonzero interval shifts one code bit (1 at or above the
//   threshold), an edge with zero interval or a timeout after an edge ends a frame.
// result queue side: while empty is low, text_byte_o / last_of_frame_o hold the
//   oldest byte; pop takes it. a frame gives 8 upper-case hex digits, msb first,
//   then a newline with last_of_frame_o set.
// config: cfg_valid_i / cfg_ready_o write bit_threshold; ready is always high,
//   write only while idle.
// throughput: one event per cycle while the two-entry frame queue has room;
//   bytes leave at one per cycle while pop is high, with a gap between frames
//   while the serializer loads the next code.
// a frame's first digit shows after the frame queue write and the serializer load.
// reset clears the code, the pending flag and both queues; threshold returns
//   to 4096. when pop stays low the output byte holds, the serializer stops,
//   the frame queue fills, and full then holds off further events.
`include "ir_pulse_code_decoder_unit_defines.svh"

module ir_pulse_code_decoder_unit import irpcd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [THR_W-1:0] cfg_data_i,
  input  logic             push,
  output logic             full,
  input  logic             operation_i,
  input  logic [15:0]      interval_i,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       text_byte_o,
  output logic             last_of_frame_o
);

  logic   frame_push;
  frame_t frame_in, frame_out;
  logic   fq_empty, fq_pop, back_busy;

  assign cfg_ready_o = 1'b1;

  irpcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (push && !full),
    .operation_i  (operation_i),
    .interval_i   (interval_i),
    .frame_push_o (frame_push),
    .frame_o      (frame_in)
  );

  irpcd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (frame_push),
    .data_i  (frame_in),
    .full_o  (full),
    .pop_i   (fq_pop),
    .empty_o (fq_empty),
    .data_o  (frame_out)
  );

  irpcd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fq_empty_i      (fq_empty),
    .fq_data_i       (frame_out),
    .fq_pop_o        (fq_pop),
    .busy_o          (back_busy),
    .pop_i           (pop),
    .empty_o         (empty),
    .text_byte_o     (text_byte_o),
    .last_of_frame_o (last_of_frame_o)
  );

  `IRPCD_ASSERT_IMPLY(a_nl_on_last, clk_i, rst_ni,
    !empty && last_of_frame_o, text_byte_o == CHAR_NL, "last beat is not a newline")
  `IRPCD_ASSERT_IMPLY(a_digit_is_hex, clk_i, rst_ni,
    !empty && !last_of_frame_o,
    (text_byte_o >= 8'd48 && text_byte_o <= 8'd57) ||
    (text_byte_o >= 8'd65 && text_byte_o <= 8'd70),
    "digit beat is not upper-case hex")
  `IRPCD_ASSERT_IMPLY(a_no_frame_loss, clk_i, rst_ni,
    frame_push, !full, "frame pushed into a full queue")
  `IRPCD_ASSERT_NEXT(a_load_starts, clk_i, rst_ni,
    fq_pop, back_busy, "serializer did not start on load")

endmodule
